[rtl/core/fasc_pkg.sv]
// Package: constants, ROM and shared types for the angle sine/cosine pipeline.
package fasc_pkg;

    localparam logic [31:0] STEP_RAD  = 32'd52707179;
    localparam logic [31:0] INV2PI_HI = 32'd341782637;
    localparam logic [31:0] INV2PI_LO = 32'd1692680576;
    localparam logic [15:0] TAYLOR_K  = 16'd43691;
    localparam logic signed [63:0] Q31_MAX = 64'sh7FFFFFFF;
    localparam logic signed [63:0] Q31_MIN = -64'sh80000000;
    localparam logic [31:0] OCTANT_MASK = 32'h3FFFFFFF;

    typedef struct packed {
        logic        negative;
        logic [1:0]  quad;
        logic [5:0]  seg;
        logic [23:0] res;
    } turn_t;

    function automatic logic [30:0] qcos(input logic [6:0] i);
        logic [30:0] v;
        begin
            case (i)
                7'd0: v = 31'd2147483647; 7'd1: v = 31'd2146836866;
                7'd2: v = 31'd2144896910; 7'd3: v = 31'd2141664948;
                7'd4: v = 31'd2137142927; 7'd5: v = 31'd2131333572;
                7'd6: v = 31'd2124240380; 7'd7: v = 31'd2115867626;
                7'd8: v = 31'd2106220352; 7'd9: v = 31'd2095304370;
                7'd10: v = 31'd2083126254; 7'd11: v = 31'd2069693342;
                7'd12: v = 31'd2055013723; 7'd13: v = 31'd2039096241;
                7'd14: v = 31'd2021950484; 7'd15: v = 31'd2003586779;
                7'd16: v = 31'd1984016189; 7'd17: v = 31'd1963250501;
                7'd18: v = 31'd1941302225; 7'd19: v = 31'd1918184581;
                7'd20: v = 31'd1893911494; 7'd21: v = 31'd1868497586;
                7'd22: v = 31'd1841958164; 7'd23: v = 31'd1814309216;
                7'd24: v = 31'd1785567396; 7'd25: v = 31'd1755750017;
                7'd26: v = 31'd1724875040; 7'd27: v = 31'd1692961062;
                7'd28: v = 31'd1660027308; 7'd29: v = 31'd1626093616;
                7'd30: v = 31'd1591180426; 7'd31: v = 31'd1555308768;
                7'd32: v = 31'd1518500250; 7'd33: v = 31'd1480777044;
                7'd34: v = 31'd1442161874; 7'd35: v = 31'd1402678000;
                7'd36: v = 31'd1362349204; 7'd37: v = 31'd1321199781;
                7'd38: v = 31'd1279254516; 7'd39: v = 31'd1236538675;
                7'd40: v = 31'd1193077991; 7'd41: v = 31'd1148898640;
                7'd42: v = 31'd1104027237; 7'd43: v = 31'd1058490808;
                7'd44: v = 31'd1012316784; 7'd45: v = 31'd965532978;
                7'd46: v = 31'd918167572;  7'd47: v = 31'd870249095;
                7'd48: v = 31'd821806413;  7'd49: v = 31'd772868706;
                7'd50: v = 31'd723465451;  7'd51: v = 31'd673626408;
                7'd52: v = 31'd623381598;  7'd53: v = 31'd572761285;
                7'd54: v = 31'd521795963;  7'd55: v = 31'd470516330;
                7'd56: v = 31'd418953276;  7'd57: v = 31'd367137861;
                7'd58: v = 31'd315101295;  7'd59: v = 31'd262874923;
                7'd60: v = 31'd210490206;  7'd61: v = 31'd157978697;
                7'd62: v = 31'd105372028;  7'd63: v = 31'd52701887;
                default: v = 31'd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/core/fasc_reduce.sv]
// Range reduction: float bits to quadrant, segment and residual (3 stages).
module fasc_reduce
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [31:0]          angle_bits,
    output logic                 out_valid,
    output fasc_pkg::turn_t      turn
);
    localparam logic [31:0] INV2PI_HI_W = fasc_pkg::INV2PI_HI;
    localparam logic [31:0] INV2PI_LO_W = fasc_pkg::INV2PI_LO;

    // stage 1: split and multiply
    logic        v1_reg;
    logic        neg1_reg, nan1_reg;
    logic [5:0]  s1_reg;       // right shift amount when left1_reg = 0
    logic        left1_reg;
    logic [4:0]  ls1_reg;
    logic        zero1_reg;
    logic [55:0] ph1_reg;
    logic [55:0] pl1_reg;
    // stage 2: sum
    logic        v2_reg, neg2_reg, nan2_reg, left2_reg, zero2_reg;
    logic [5:0]  s2_reg;
    logic [4:0]  ls2_reg;
    logic [63:0] prod2_reg;
    // stage 3: shift
    logic        v3_reg;
    fasc_pkg::turn_t turn3_reg;

    logic [7:0]  ex;
    logic [23:0] sig;
    logic signed [9:0] k;
    logic [31:0] frac;

    always_comb
    begin
        ex = angle_bits[30:23];
        sig = (ex != 8'd0) ? {1'b1, angle_bits[22:0]} : {1'b0, angle_bits[22:0]};
        // k = pw - 22
        k = (ex != 8'd0) ? ($signed({2'b00, ex}) - 10'sd149) : -10'sd148;
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= angle_bits[31];
        nan1_reg  <= (ex == 8'hFF);
        left1_reg <= (k >= 10'sd0);
        zero1_reg <= (k >= 10'sd32) || (k <= -10'sd54);
        ls1_reg   <= k[4:0];
        s1_reg    <= 6'(-k);
        ph1_reg   <= 56'(sig * INV2PI_HI_W);
        pl1_reg   <= 56'(sig * INV2PI_LO_W);
        neg2_reg  <= neg1_reg;
        nan2_reg  <= nan1_reg;
        left2_reg <= left1_reg;
        zero2_reg <= zero1_reg;
        ls2_reg   <= ls1_reg;
        s2_reg    <= s1_reg;
        prod2_reg <= 64'(ph1_reg) + 64'(pl1_reg >> 31);
        turn3_reg.negative <= neg2_reg;
        turn3_reg.quad     <= frac[31:30];
        turn3_reg.seg      <= frac[29:24];
        turn3_reg.res      <= frac[23:0];
    end

    always_comb
    begin
        if (nan2_reg || zero2_reg)
            frac = 32'd0;
        else if (left2_reg)
            frac = prod2_reg[31:0] << ls2_reg;
        else
            frac = 32'(prod2_reg >> s2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign turn      = turn3_reg;
endmodule

[rtl/core/fasc_taylor.sv]
// Taylor correction of the residual and ROM lookup (pipelined multiplies).
module fasc_taylor
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  fasc_pkg::turn_t      turn,
    output logic                 out_valid,
    output fasc_pkg::turn_t      turn_out,
    output logic [32:0]          cd,
    output logic [31:0]          sd,
    output logic [30:0]          cj,
    output logic [30:0]          sj
);
    localparam int NST = 4;
    logic [NST-1:0]  v_reg;
    fasc_pkg::turn_t t_reg [NST];
    logic [31:0] d1_reg;
    logic [31:0] d2a_reg, d2b_reg;
    logic [31:0] d2c_reg, d3_reg, d4_reg, dc_reg;
    logic [32:0] cd_reg;
    logic [31:0] sd_reg;
    logic [30:0] cj_reg, sj_reg;
    logic [55:0] p0;
    logic [63:0] p1, p2, p3;
    logic [47:0] p4, p5;

    always_comb
    begin
        p0 = 56'(turn.res * fasc_pkg::STEP_RAD);
        p1 = 64'(d1_reg) * 64'(d1_reg);
        p2 = 64'(d2a_reg) * 64'(d2b_reg);
        p3 = 64'(d2a_reg) * 64'(d2a_reg);
        p4 = 48'(d3_reg) * 48'(fasc_pkg::TAYLOR_K);
        p5 = 48'(d4_reg) * 48'(fasc_pkg::TAYLOR_K);
    end

    always_ff @(posedge clk)
    begin
        // stage A: d
        d1_reg  <= p0[55:24];
        t_reg[0] <= turn;
        // stage B: d^2
        d2a_reg <= p1[62:31];
        d2b_reg <= d1_reg;
        t_reg[1] <= t_reg[0];
        // stage C: d^3, d^4
        d3_reg  <= p2[62:31];
        d4_reg  <= p3[62:31];
        d2c_reg <= d2a_reg;
        dc_reg  <= d2b_reg;
        t_reg[2] <= t_reg[1];
        // stage D: K products
        t_reg[3] <= t_reg[2];
        cd_reg <= 33'h080000000 - 33'(d2c_reg >> 1) + 33'(p5 >> 20);
        sd_reg <= dc_reg - 32'(p4 >> 18);
        cj_reg <= fasc_pkg::qcos({1'b0, t_reg[2].seg});
        sj_reg <= fasc_pkg::qcos(7'd64 - {1'b0, t_reg[2].seg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    assign out_valid = v_reg[3];
    assign turn_out  = t_reg[3];
    assign cd = cd_reg;
    assign sd = sd_reg;
    assign cj = cj_reg;
    assign sj = sj_reg;
endmodule

[rtl/core/fasc_rotate.sv]
// Rounded rotation, quadrant fold, sign and saturation.
module fasc_rotate
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  fasc_pkg::turn_t      turn,
    input  logic [32:0]          cd,
    input  logic [31:0]          sd,
    input  logic [30:0]          cj,
    input  logic [30:0]          sj,
    output logic                 out_valid,
    output logic signed [31:0]   cos_q31,
    output logic signed [31:0]   sin_q31
);
    logic        v1_reg, v2_reg, v3_reg;
    fasc_pkg::turn_t t1_reg, t2_reg;
    logic signed [65:0] cc_reg, cs_reg, sc_reg, ss_reg;
    logic signed [63:0] cq_reg, sq_reg;
    logic signed [31:0] cos_reg, sin_reg;
    logic signed [63:0] cq, sq, cc, ss;
    logic signed [66:0] csum, ssum;

    always_comb
    begin
        csum = 67'(cc_reg) - 67'(cs_reg) + 67'sd1073741824;
        ssum = 67'(sc_reg) + 67'(ss_reg) + 67'sd1073741824;
        cq = 64'(csum >>> 31);
        sq = 64'(ssum >>> 31);
        cc = t2_reg.quad[0] ? sq_reg : cq_reg;
        ss = t2_reg.quad[0] ? cq_reg : sq_reg;
        if (t2_reg.quad == 2'd1 || t2_reg.quad == 2'd2)
            cc = -cc;
        if (t2_reg.quad[1] ^ t2_reg.negative)
            ss = -ss;
    end

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        begin
            if (v > fasc_pkg::Q31_MAX)
                return 32'h7FFFFFFF;
            else if (v < fasc_pkg::Q31_MIN)
                return 32'h80000000;
            return v[31:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        // products of the 31-bit ROM values with the 33-bit cd and the signed 32-bit sd
        cc_reg <= $signed({35'd0, cj}) * $signed({33'd0, cd});
        cs_reg <= $signed({35'd0, sj}) * $signed({{34{sd[31]}}, sd});
        sc_reg <= $signed({35'd0, sj}) * $signed({33'd0, cd});
        ss_reg <= $signed({35'd0, cj}) * $signed({{34{sd[31]}}, sd});
        t1_reg <= turn;
        cq_reg <= cq;
        sq_reg <= sq;
        t2_reg <= t1_reg;
        cos_reg <= sat(cc);
        sin_reg <= sat(ss);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign cos_q31 = cos_reg;
    assign sin_q31 = sin_reg;
endmodule

[rtl/core/float_angle_sine_cosine_q31.sv]
// Top level: pipelined sine/cosine of a single-precision angle in Q31.
// Usage:
//   Drive angle_bits with the raw float bits of an angle in radians and
//   raise start; the transfer happens on any rising edge with start high.
//   busy is always low, so one angle can enter every cycle.
//   cos_q31 and sin_q31 appear once the angle has passed the pipeline, marked
//   by done for exactly one cycle; results leave in the order the angles entered.
//   The pipeline has 3 reduction stages (multiply by 1/(2*pi), sum, shift),
//   4 Taylor stages (d, d^2, d^3/d^4, correction and ROM), and 3 rotation
//   stages (products, rounding, quadrant fold with sign and saturation).
//   Throughput is one result per cycle.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall: done must be taken in the cycle it shows.
module float_angle_sine_cosine_q31
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        angle_bits,
    output logic               done,
    output logic signed [31:0] cos_q31,
    output logic signed [31:0] sin_q31
);
    logic            r_valid, t_valid;
    fasc_pkg::turn_t r_turn, t_turn;
    logic [32:0]     cd;
    logic [31:0]     sd;
    logic [30:0]     cj, sj;

    assign busy = 1'b0;

    fasc_reduce u_reduce
    (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .angle_bits(angle_bits),
        .out_valid(r_valid), .turn(r_turn)
    );

    fasc_taylor u_taylor
    (
        .clk(clk), .rst_n(rst_n), .in_valid(r_valid), .turn(r_turn),
        .out_valid(t_valid), .turn_out(t_turn), .cd(cd), .sd(sd), .cj(cj), .sj(sj)
    );

    fasc_rotate u_rotate
    (
        .clk(clk), .rst_n(rst_n), .in_valid(t_valid), .turn(t_turn),
        .cd(cd), .sd(sd), .cj(cj), .sj(sj),
        .out_valid(done), .cos_q31(cos_q31), .sin_q31(sin_q31)
    );
endmodule

[rtl/core/fasc_checker.sv]
// Port-level checker for the sine/cosine pipeline, bound to the top level.
module fasc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] cos_q31,
    input logic signed [31:0] sin_q31
);
    // every transfer is followed by a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##10 done)
        else $error("missing result");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 10))
        else $error("result without transfer");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    // a zero cosine and zero sine together cannot happen
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(cos_q31 == 32'sd0 && sin_q31 == 32'sd0))
        else $error("degenerate result");
endmodule

bind float_angle_sine_cosine_q31 fasc_checker u_fasc_checker
(
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .cos_q31(cos_q31), .sin_q31(sin_q31)
);

[tb/testbench.sv]
// Testbench for the float angle sine/cosine block: table and random angles checked by a predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LATENCY = 10;
    localparam int unsigned N_RANDOM = 1530;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [31:0] angle_bits;
    logic done;
    logic signed [31:0] cos_q31;
    logic signed [31:0] sin_q31;

    typedef struct {
        logic [31:0] cos_v;
        logic [31:0] sin_v;
    } sincos_t;

    typedef struct {
        logic [31:0] angle;
        logic        has_value;
        logic [31:0] cos_v;
        logic [31:0] sin_v;
    } row_t;

    sincos_t pending_q[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned sender_idle_pct;

    float_angle_sine_cosine_q31 dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .angle_bits(angle_bits),
        .done(done),
        .cos_q31(cos_q31),
        .sin_q31(sin_q31)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [31:0] turn_of(input logic [31:0] bits);
        logic [7:0] ex;
        logic [23:0] sig;
        int pw;
        int k;
        int s;
        logic [63:0] prod;
        logic [31:0] lo;
        logic [31:0] hi;
        begin
            ex = bits[30:23];
            if (ex == 8'hFF)
                return 32'd0;
            if (ex != 8'd0)
            begin
                sig = {1'b1, bits[22:0]};
                pw = int'(ex) - 127;
            end
            else
            begin
                sig = {1'b0, bits[22:0]};
                pw = -126;
            end
            prod = 64'(sig) * 64'(fasc_pkg::INV2PI_HI)
                 + ((64'(sig) * 64'(fasc_pkg::INV2PI_LO)) >> 31);
            k = pw - 22;
            lo = prod[31:0];
            hi = prod[63:32];
            if (k >= 0)
                return (k >= 32) ? 32'd0 : (lo << k);
            s = -k;
            if (s < 32)
                return (lo >> s) | (hi << (32 - s));
            if (s < 54)
                return hi >> (s - 32);
            return 32'd0;
        end
    endfunction

    function automatic longint unsigned_rom(input int i);
        return longint'(fasc_pkg::qcos(7'(i)));
    endfunction

    function automatic longint floor_div31(input longint v);
        return v >>> 31;
    endfunction

    function automatic longint clamp_q31(input longint v);
        if (v > 64'sh7FFFFFFF)
            return 64'sh7FFFFFFF;
        if (v < -64'sh80000000)
            return -64'sh80000000;
        return v;
    endfunction

    function automatic sincos_t sincos_of(input logic [31:0] bits);
        logic [31:0] turn;
        logic [1:0] quad;
        logic [5:0] seg;
        logic [23:0] res;
        longint d, d2, d3, cd, sd, cj, sj, cq, sq, cc, ss;
        sincos_t r;
        begin
            turn = turn_of(bits);
            quad = turn[31:30];
            seg = turn[29:24];
            res = turn[23:0];
            d = longint'((64'(res) * 64'(fasc_pkg::STEP_RAD)) >> 24);
            d2 = (d * d) >>> 31;
            d3 = (d2 * d) >>> 31;
            cd = (64'sd1 <<< 31) - (d2 >>> 1)
               + ((((d2 * d2) >>> 31) * longint'(fasc_pkg::TAYLOR_K)) >>> 20);
            sd = d - ((d3 * longint'(fasc_pkg::TAYLOR_K)) >>> 18);
            cj = unsigned_rom(seg);
            sj = unsigned_rom(64 - seg);
            cq = floor_div31(cj * cd - sj * sd + (64'sd1 <<< 30));
            sq = floor_div31(sj * cd + cj * sd + (64'sd1 <<< 30));
            cc = quad[0] ? sq : cq;
            ss = quad[0] ? cq : sq;
            if (quad == 2'd1 || quad == 2'd2)
                cc = -cc;
            if (quad[1])
                ss = -ss;
            if (bits[31])
                ss = -ss;
            r.cos_v = 32'(clamp_q31(cc));
            r.sin_v = 32'(clamp_q31(ss));
            return r;
        end
    endfunction

    // Directed angles: zero, signs, NaN, infinity, subnormals, huge and tiny exponents.
    row_t angle_table[] = '{
        '{32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'h7F80_0000, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'hFF80_0000, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'h7FC0_0000, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'h0000_0001, 1'b0, 32'h0, 32'h0},
        '{32'h007F_FFFF, 1'b0, 32'h0, 32'h0},
        '{32'h8080_0000, 1'b0, 32'h0, 32'h0},
        '{32'h7F7F_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'hFF7F_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000},
        '{32'h4B80_0000, 1'b0, 32'h0, 32'h0},
        '{32'h4C00_0000, 1'b0, 32'h0, 32'h0},
        '{32'h3F80_0000, 1'b0, 32'h0, 32'h0},
        '{32'hBF80_0000, 1'b0, 32'h0, 32'h0},
        '{32'h3FC9_0FDB, 1'b0, 32'h0, 32'h0},
        '{32'h4049_0FDB, 1'b0, 32'h0, 32'h0},
        '{32'hC096_CBE4, 1'b0, 32'h0, 32'h0},
        '{32'h40C9_0FDB, 1'b0, 32'h0, 32'h0},
        '{32'h3F49_0FDB, 1'b0, 32'h0, 32'h0},
        '{32'h3400_0000, 1'b0, 32'h0, 32'h0},
        '{32'h4000_0000, 1'b0, 32'h0, 32'h0}
    };

    function automatic logic [31:0] random_angle();
        int unsigned pick;
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                // Mostly moderate magnitudes, where every quadrant and segment is reached.
                return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            if (pick == 9)
                return {1'($urandom), 8'($urandom_range(0, 1)) == 8'd0 ? 8'd0 : 8'hFF,
                        23'($urandom)};
            return $urandom;
        end
    endfunction

    task automatic send_angle(input logic [31:0] a, input logic has_value,
                              input logic [31:0] c, input logic [31:0] s);
        sincos_t e;
        begin
            while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            if (has_value)
            begin
                e.cos_v = c;
                e.sin_v = s;
            end
            else
                e = sincos_of(a);
            start <= 1'b1;
            angle_bits <= a;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_q.push_back(e);
            @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (done)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result with nothing expected: cos %h sin %h", cos_q31, sin_q31);
                    errors = errors + 1;
                end
                else
                begin
                    if (cos_q31 !== pending_q[0].cos_v)
                    begin
                        $error("cos_q31 expected %h actual %h", pending_q[0].cos_v, cos_q31);
                        errors = errors + 1;
                    end
                    if (sin_q31 !== pending_q[0].sin_v)
                    begin
                        $error("sin_q31 expected %h actual %h", pending_q[0].sin_v, sin_q31);
                        errors = errors + 1;
                    end
                    void'(pending_q.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("float_angle_sine_cosine_q31 verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        sender_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        angle_bits = 32'd0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (angle_table[i])
            send_angle(angle_table[i].angle, angle_table[i].has_value,
                       angle_table[i].cos_v, angle_table[i].sin_v);

        // Hold off until the pipeline has drained once.
        start <= 1'b0;
        @(negedge clk);
        while (pending_q.size() != 0)
            @(negedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 8 : ((phase == 1) ? 63 : 0);
            for (int n = 0; n < N_RANDOM / 3; n++)
                send_angle(random_angle(), 1'b0, 32'h0, 32'h0);
        end
        start <= 1'b0;

        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);

        if (errors == 0)
            $display("float_angle_sine_cosine_q31 verification clean");
        else
            $display("float_angle_sine_cosine_q31 verification failed");
        $finish;
    end
endmodule
